@@ sv/cdq_pkg.sv @@
// package for the circular deque: word width, operation and status codes,
// and the control word that the top level hands to every storage cell
// no dependencies
package cdq_pkg;

    localparam int WORD_W = 32;

    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_PUSH_REAR  = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_REAR   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_LOAD_TAIL
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     tail_sel;
    } cell_ctl_t;

endpackage

@@ sv/circular_deque.sv @@
// circular_deque top level: a row of DEPTH cdq_cell words kept in deque order
// (front in cell 0), the entry count and the registered result
// depends on cdq_pkg and cdq_cell
// the result appears with done in the cycle after start is taken
// throughput: one operation per cycle, set by the shift of the cell row
// busy stays low; results are held for one cycle only and cannot be stalled
// reset: count and result strobe clear asynchronously; cell words are not reset
module circular_deque
#(
    parameter int DEPTH = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            opcode,
    input  logic signed [cdq_pkg::WORD_W-1:0]     data_value,
    output logic                                  done,
    output logic [1:0]                            status,
    output logic signed [cdq_pkg::WORD_W-1:0]     popped_value,
    output logic [$clog2(DEPTH+1)-1:0]            occupancy,
    output logic                                  is_full,
    output logic                                  is_empty
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [cdq_pkg::WORD_W-1:0] cell_word [DEPTH];

    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic                        done_reg;
    logic [1:0]                  status_reg;
    logic [1:0]                  status_next;
    logic [cdq_pkg::WORD_W-1:0]  popped_reg;
    logic [cdq_pkg::WORD_W-1:0]  popped_next;
    logic [CW-1:0]               occ_reg;
    logic                        full_reg;
    logic                        empty_reg;

    logic                        accept;
    logic                        is_push;
    logic                        cur_full;
    logic                        cur_empty;
    logic                        push_ok;
    logic                        pop_ok;
    cdq_pkg::cell_op_t           row_op;
    logic [cdq_pkg::WORD_W-1:0]  rear_word;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign is_push   = (opcode == cdq_pkg::OP_PUSH_FRONT) || (opcode == cdq_pkg::OP_PUSH_REAR);
    assign cur_full  = (count_reg == CW'(DEPTH));
    assign cur_empty = (count_reg == '0);
    assign push_ok   = accept && is_push && !cur_full;
    assign pop_ok    = accept && !is_push && !cur_empty;

    // word at the rear of the row
    always_comb
    begin
        rear_word = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (count_reg == CW'(k + 1))
            begin
                rear_word = rear_word | cell_word[k];
            end
        end
    end

    always_comb
    begin
        row_op      = cdq_pkg::CELL_HOLD;
        count_next  = count_reg;
        status_next = cdq_pkg::ST_DONE;
        popped_next = '0;
        if (accept)
        begin
            if (is_push)
            begin
                if (cur_full)
                begin
                    status_next = cdq_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    if (opcode == cdq_pkg::OP_PUSH_FRONT)
                    begin
                        row_op = cdq_pkg::CELL_SHIFT_UP;
                    end
                    else
                    begin
                        row_op = cdq_pkg::CELL_LOAD_TAIL;
                    end
                end
            end
            else
            begin
                if (cur_empty)
                begin
                    status_next = cdq_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    if (opcode == cdq_pkg::OP_POP_FRONT)
                    begin
                        row_op      = cdq_pkg::CELL_SHIFT_DOWN;
                        popped_next = cell_word[0];
                    end
                    else
                    begin
                        popped_next = rear_word;
                    end
                end
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            cdq_pkg::cell_ctl_t         ctl;
            logic [cdq_pkg::WORD_W-1:0] lower_w;
            logic [cdq_pkg::WORD_W-1:0] upper_w;

            assign ctl.op       = row_op;
            assign ctl.tail_sel = (count_reg == CW'(i));

            if (i == 0)
            begin : g_first
                assign lower_w = data_value;
            end
            else
            begin : g_mid
                assign lower_w = cell_word[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign upper_w = cell_word[i];
            end
            else
            begin : g_inner
                assign upper_w = cell_word[i+1];
            end

            cdq_cell u_cell
            (
                .clk        (clk),
                .ctl        (ctl),
                .lower_word (lower_w),
                .upper_word (upper_w),
                .push_word  (data_value),
                .word       (cell_word[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        popped_reg <= popped_next;
        occ_reg    <= count_next;
        full_reg   <= (count_next == CW'(DEPTH));
        empty_reg  <= (count_next == '0);
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign occupancy    = occ_reg;
    assign is_full      = full_reg;
    assign is_empty     = empty_reg;

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("result strobe missing after accepted operation");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == cdq_pkg::ST_FULL) |-> (is_full && popped_value == '0))
        else $error("full rejection with deque not full");

    a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == cdq_pkg::ST_EMPTY) |-> (is_empty && popped_value == '0))
        else $error("empty rejection with deque not empty");

    a_pop_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_ok || push_ok) |=> (count_reg != $past(count_reg)))
        else $error("successful operation left count unchanged");

endmodule

@@ sv/cdq_cell.sv @@
// one storage cell of the deque row: holds one word and takes its neighbor's
// word on a shift, or the pushed word when it is the slot just past the rear
// depends on cdq_pkg
module cdq_cell
(
    input  logic                           clk,
    input  cdq_pkg::cell_ctl_t             ctl,
    input  logic [cdq_pkg::WORD_W-1:0]     lower_word,
    input  logic [cdq_pkg::WORD_W-1:0]     upper_word,
    input  logic [cdq_pkg::WORD_W-1:0]     push_word,
    output logic [cdq_pkg::WORD_W-1:0]     word
);

    logic [cdq_pkg::WORD_W-1:0] word_reg;
    logic [cdq_pkg::WORD_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        case (ctl.op)
            cdq_pkg::CELL_SHIFT_UP:   word_next = lower_word;
            cdq_pkg::CELL_SHIFT_DOWN: word_next = upper_word;
            cdq_pkg::CELL_LOAD_TAIL:
            begin
                if (ctl.tail_sel)
                begin
                    word_next = push_word;
                end
            end
            default:                  word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

@@ dv/circular_deque_tb.sv @@
// self-checking testbench for circular_deque: directed corner cases, then random push/pop
// phases, checked word by word against an in-bench deque predictor
// depends on cdq_pkg and circular_deque
`timescale 1ns / 100ps

module circular_deque_tb;

    localparam int WORD_W = cdq_pkg::WORD_W;
    localparam int DEPTH = 16;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int RANDOM_OPS = 1750;
    localparam int QUIET_TAIL = 150;

    typedef struct {
        logic [1:0]               op;
        logic signed [WORD_W-1:0] value;
    } deque_op_t;

    typedef struct {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] popped;
        logic [OCC_W-1:0]         occ;
        logic                     full;
        logic                     empty;
    } deque_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [1:0]               opcode = cdq_pkg::OP_PUSH_FRONT;
    logic signed [WORD_W-1:0] data_value = '0;
    logic                     done;
    logic [1:0]               status;
    logic signed [WORD_W-1:0] popped_value;
    logic [OCC_W-1:0]         occupancy;
    logic                     is_full;
    logic                     is_empty;

    deque_op_t     pending_ops[$];
    deque_result_t expected_results[$];

    // predictor state
    logic signed [WORD_W-1:0] ring[DEPTH];
    logic [3:0]               front_pos = '0;
    logic [3:0]               rear_pos = '0;
    int                       stored = 0;

    logic taken = 1'b0;
    int   gap_left = 0;
    int   errors = 0;
    int   n_push = 0;
    int   n_pop = 0;
    int   n_full_rej = 0;
    int   n_empty_rej = 0;

    circular_deque #(.DEPTH(DEPTH)) dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .data_value   (data_value),
        .done         (done),
        .status       (status),
        .popped_value (popped_value),
        .occupancy    (occupancy),
        .is_full      (is_full),
        .is_empty     (is_empty)
    );

    always #5 clk = ~clk;

    function automatic deque_result_t deque_apply(logic [1:0] op, logic signed [WORD_W-1:0] value);
        deque_result_t r;
        r.status = cdq_pkg::ST_DONE;
        r.popped = '0;
        if (op == cdq_pkg::OP_PUSH_FRONT || op == cdq_pkg::OP_PUSH_REAR)
        begin
            if (stored >= DEPTH)
                r.status = cdq_pkg::ST_FULL;
            else
            begin
                if (stored == 0)
                begin
                    front_pos = '0;
                    rear_pos = '0;
                    ring[0] = value;
                end
                else if (op == cdq_pkg::OP_PUSH_FRONT)
                begin
                    front_pos = front_pos - 4'd1;
                    ring[front_pos] = value;
                end
                else
                begin
                    rear_pos = rear_pos + 4'd1;
                    ring[rear_pos] = value;
                end
                stored++;
            end
        end
        else
        begin
            if (stored == 0)
                r.status = cdq_pkg::ST_EMPTY;
            else
            begin
                r.popped = (op == cdq_pkg::OP_POP_FRONT) ? ring[front_pos] : ring[rear_pos];
                if (stored == 1)
                begin
                    front_pos = '0;
                    rear_pos = '0;
                end
                else if (op == cdq_pkg::OP_POP_FRONT)
                    front_pos = front_pos + 4'd1;
                else
                    rear_pos = rear_pos - 4'd1;
                stored--;
            end
        end
        r.occ = stored[OCC_W-1:0];
        r.full = (stored == DEPTH);
        r.empty = (stored == 0);
        return r;
    endfunction

    task automatic compare_field(string name, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic add_op(logic [1:0] op, logic signed [WORD_W-1:0] value);
        deque_op_t w;
        w.op = op;
        w.value = value;
        pending_ops.push_back(w);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    // driver: new word presented at the falling edge once the last one was taken
    always @(negedge clk)
    begin
        deque_op_t nxt;
        logic      drive;
        drive = start;
        if (!rst_n)
            drive = 1'b0;
        else if (!start || taken)
        begin
            drive = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_ops.size() > 0)
            begin
                if (pending_ops.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
                    gap_left = $urandom_range(1, 15) - 1;
                else
                begin
                    nxt = pending_ops.pop_front();
                    opcode <= nxt.op;
                    data_value <= nxt.value;
                    drive = 1'b1;
                end
            end
        end
        start <= drive;
    end

    // monitor: check returned words, then predict the word taken at this edge
    always @(posedge clk)
    begin
        deque_result_t e;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no expectation pending: status %0d", status);
                    errors++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    compare_field("status", e.status, status);
                    compare_field("popped_value", e.popped, popped_value);
                    compare_field("occupancy", e.occ, occupancy);
                    compare_field("is_full", e.full, is_full);
                    compare_field("is_empty", e.empty, is_empty);
                end
            end
            if (start && !busy)
            begin
                e = deque_apply(opcode, data_value);
                expected_results.push_back(e);
                case (e.status)
                    cdq_pkg::ST_FULL: n_full_rej++;
                    cdq_pkg::ST_EMPTY: n_empty_rej++;
                    default:
                        if (opcode == cdq_pkg::OP_PUSH_FRONT || opcode == cdq_pkg::OP_PUSH_REAR)
                            n_push++;
                        else
                            n_pop++;
                endcase
            end
        end
        taken <= rst_n && start && !busy;
    end

    initial
    begin
        int push_bias;
        int seg_len;
        int left;
        for (int i = 0; i < DEPTH; i++)
            ring[i] = '0;

        // empty rejects, extremes, fill to full, full rejects
        add_op(cdq_pkg::OP_POP_FRONT, 32'sh1234_5678);
        add_op(cdq_pkg::OP_POP_REAR, -1);
        add_op(cdq_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
        add_op(cdq_pkg::OP_PUSH_REAR, 32'sh7fff_ffff);
        add_op(cdq_pkg::OP_POP_FRONT, '0);
        add_op(cdq_pkg::OP_POP_REAR, '0);
        for (int i = 0; i < DEPTH; i++)
            add_op((i % 2) ? cdq_pkg::OP_PUSH_REAR : cdq_pkg::OP_PUSH_FRONT,
                   (i % 3 == 0) ? 32'sh5555_5555 : ((i % 3 == 1) ? -1 : 32'shaaaa_aaaa));
        add_op(cdq_pkg::OP_PUSH_FRONT, 32'sh0f0f_0f0f);
        add_op(cdq_pkg::OP_PUSH_REAR, 32'shf0f0_f0f0);
        add_op(cdq_pkg::OP_POP_FRONT, '0);

        // random phases, each picked at random among filling, draining and mixed traffic
        left = RANDOM_OPS;
        while (left > 0)
        begin
            seg_len = $urandom_range(8, 60);
            case ($urandom_range(0, 2))
                0: push_bias = 80;
                1: push_bias = 20;
                default: push_bias = 50;
            endcase
            for (int i = 0; i < seg_len && left > 0; i++, left--)
            begin
                if ($urandom_range(0, 99) < push_bias)
                    add_op($urandom_range(0, 1) ? cdq_pkg::OP_PUSH_REAR
                                                : cdq_pkg::OP_PUSH_FRONT,
                           pick_value());
                else
                    add_op($urandom_range(0, 1) ? cdq_pkg::OP_POP_REAR
                                                : cdq_pkg::OP_POP_FRONT,
                           $urandom);
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_ops.size() > 0 || start || expected_results.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);

        $display("covered %0d pushes and %0d pops, %0d rejected as full, %0d as empty",
                 n_push, n_pop, n_full_rej, n_empty_rej);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d words still expected", expected_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
sv/cdq_pkg.sv
sv/cdq_cell.sv
sv/circular_deque.sv
dv/circular_deque_tb.sv
